[rtl/core/bpt_pkg.sv]
// Shared constants, types and encodings of the beacon presence table.
package bpt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORG_WORD0 = 3'd0,
    CFG_ORG_WORD1 = 3'd1,
    CFG_ORG_WORD2 = 3'd2,
    CFG_ORG_WORD3 = 3'd3,
    CFG_THRESHOLD = 3'd4,
    CFG_TIMEOUT   = 3'd5
  } cfg_reg_t;

  localparam logic [31:0]        ORG_WORD0_RST = 32'hE2C56DB5;
  localparam logic [31:0]        ORG_WORD1_RST = 32'hDFFB48D2;
  localparam logic [31:0]        ORG_WORD2_RST = 32'hB060D0F5;
  localparam logic [31:0]        ORG_WORD3_RST = 32'hA71096E0;
  localparam logic signed [7:0]  THRESHOLD_RST = -8'sd90;
  localparam logic [15:0]        TIMEOUT_RST   = 16'd2;

  typedef enum logic [1:0] {
    KIND_LEFT    = 2'd0,
    KIND_ENTERED = 2'd1,
    KIND_DROPPED = 2'd2
  } event_kind_t;

  // One classified report waiting for the table pass.
  typedef struct packed {
    logic [15:0] major_id;
    logic [15:0] minor_id;
    logic [31:0] now_seconds;
    logic        accept;
  } bpt_job_t;

  typedef struct packed {
    logic [15:0] major_id;
    logic [15:0] minor_id;
    logic [31:0] last_seen;
  } bpt_entry_t;

  typedef struct packed {
    event_kind_t kind;
    logic [15:0] major_id;
    logic [15:0] minor_id;
  } bpt_event_t;

  typedef struct packed {
    logic empty;
    logic full;
  } bpt_qstat_t;

  typedef enum logic [2:0] {
    BK_IDLE   = 3'd0,
    BK_READ   = 3'd1,
    BK_EVAL   = 3'd2,
    BK_INSERT = 3'd3,
    BK_FLUSH  = 3'd4
  } back_state_t;

endpackage

[rtl/core/bpt_if.sv]
// Channel interfaces of the beacon presence table: reports, events and configuration.
interface bpt_in_if;
  logic              valid;
  logic              ready;
  logic [31:0]       uuid_word0;
  logic [31:0]       uuid_word1;
  logic [31:0]       uuid_word2;
  logic [31:0]       uuid_word3;
  logic [15:0]       major_id;
  logic [15:0]       minor_id;
  logic signed [7:0] strength_dbm;
  logic [31:0]       now_seconds;

  modport source (output valid, uuid_word0, uuid_word1, uuid_word2, uuid_word3,
                  major_id, minor_id, strength_dbm, now_seconds, input ready);
  modport sink (input valid, uuid_word0, uuid_word1, uuid_word2, uuid_word3,
                major_id, minor_id, strength_dbm, now_seconds, output ready);
endinterface

interface bpt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [15:0] event_major;
  logic [15:0] event_minor;
  logic        last_event;

  modport source (output valid, event_kind, event_major, event_minor, last_event,
                  input ready);
  modport sink (input valid, event_kind, event_major, event_minor, last_event,
                output ready);
endinterface

interface bpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/bpt_queue.sv]
// Short job queue between the report classifier and the table sequencer.
module bpt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bpt_pkg::bpt_job_t   push_job,
  input  logic                pop,
  output bpt_pkg::bpt_job_t   head_job,
  output bpt_pkg::bpt_qstat_t stat
);
  import bpt_pkg::*;

  bpt_job_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   fill_r, fill_nxt;
  logic                do_push, do_pop;

  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == QCNT_W'(QUEUE_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_job   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[rtl/core/bpt_front.sv]
// Front end: configuration registers and classification of incoming reports.
module bpt_front (
  input  logic                clk,
  input  logic                rst_n,
  bpt_in_if.sink              in_ch,
  bpt_cfg_if.sink             cfg_ch,
  input  bpt_pkg::bpt_qstat_t q_stat,
  output logic                q_push,
  output bpt_pkg::bpt_job_t   q_job,
  output logic [15:0]         timeout
);
  import bpt_pkg::*;

  logic [31:0]       org_word0_r, org_word0_nxt;
  logic [31:0]       org_word1_r, org_word1_nxt;
  logic [31:0]       org_word2_r, org_word2_nxt;
  logic [31:0]       org_word3_r, org_word3_nxt;
  logic signed [7:0] threshold_r, threshold_nxt;
  logic [15:0]       timeout_r, timeout_nxt;
  logic              uuid_ok;
  logic              strength_ok;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_stat.full;
  assign q_push       = in_ch.valid && in_ch.ready;
  assign timeout      = timeout_r;

  assign uuid_ok = (in_ch.uuid_word0 == org_word0_r) && (in_ch.uuid_word1 == org_word1_r) &&
                   (in_ch.uuid_word2 == org_word2_r) && (in_ch.uuid_word3 == org_word3_r);
  assign strength_ok = (in_ch.strength_dbm > threshold_r);

  always_comb begin
    q_job.major_id    = in_ch.major_id;
    q_job.minor_id    = in_ch.minor_id;
    q_job.now_seconds = in_ch.now_seconds;
    q_job.accept      = uuid_ok && strength_ok;
  end

  always_comb begin
    org_word0_nxt = org_word0_r;
    org_word1_nxt = org_word1_r;
    org_word2_nxt = org_word2_r;
    org_word3_nxt = org_word3_r;
    threshold_nxt = threshold_r;
    timeout_nxt   = timeout_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_reg_t'(cfg_ch.index))
        CFG_ORG_WORD0: org_word0_nxt = cfg_ch.data;
        CFG_ORG_WORD1: org_word1_nxt = cfg_ch.data;
        CFG_ORG_WORD2: org_word2_nxt = cfg_ch.data;
        CFG_ORG_WORD3: org_word3_nxt = cfg_ch.data;
        CFG_THRESHOLD: threshold_nxt = signed'(cfg_ch.data[7:0]);
        CFG_TIMEOUT:   timeout_nxt   = cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_word0_r <= ORG_WORD0_RST;
      org_word1_r <= ORG_WORD1_RST;
      org_word2_r <= ORG_WORD2_RST;
      org_word3_r <= ORG_WORD3_RST;
      threshold_r <= THRESHOLD_RST;
      timeout_r   <= TIMEOUT_RST;
    end else begin
      org_word0_r <= org_word0_nxt;
      org_word1_r <= org_word1_nxt;
      org_word2_r <= org_word2_nxt;
      org_word3_r <= org_word3_nxt;
      threshold_r <= threshold_nxt;
      timeout_r   <= timeout_nxt;
    end
  end

endmodule

[rtl/core/bpt_back.sv]
// Back end: table memory, expiry and compaction pass, refresh, insert and event output.
module bpt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bpt_pkg::bpt_job_t   q_head,
  input  bpt_pkg::bpt_qstat_t q_stat,
  output logic                q_pop,
  input  logic [15:0]         timeout,
  bpt_out_if.source           out_ch
);
  import bpt_pkg::*;

  bpt_entry_t        entry_mem [TABLE_DEPTH];
  bpt_entry_t        rd_data_r;

  back_state_t       state_r, state_nxt;
  bpt_job_t          job_r, job_nxt;
  logic [CNT_W-1:0]  rd_i_r, rd_i_nxt;
  logic [CNT_W-1:0]  wr_w_r, wr_w_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              found_r, found_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  bpt_event_t        pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  bpt_event_t        out_r, out_nxt;
  logic              out_last_r, out_last_nxt;

  logic              mem_re, mem_we;
  logic [IDX_W-1:0]  mem_wa;
  bpt_entry_t        mem_wd;
  bpt_event_t        new_ev;

  logic              scan_done;
  logic [31:0]       age;
  logic              expired;
  logic              hit;
  logic              room;
  logic              emit_ok;
  logic              ev_want;
  logic              flush_want;
  logic              stall;

  assign scan_done  = (rd_i_r == count_r);
  assign age        = job_r.now_seconds - rd_data_r.last_seen;
  assign expired    = (age > {16'b0, timeout});
  assign hit        = job_r.accept && (rd_data_r.major_id == job_r.major_id) &&
                      (rd_data_r.minor_id == job_r.minor_id);
  assign room       = (wr_w_r < CNT_W'(TABLE_DEPTH));
  assign emit_ok    = !out_valid_r || out_ch.ready;
  assign ev_want    = ((state_r == BK_EVAL) && expired) ||
                      ((state_r == BK_INSERT) && job_r.accept && !found_r);
  assign flush_want = (state_r == BK_FLUSH) && pend_valid_r;
  // An event can only be parked if the park slot is free or the previous one moves on to the output register.
  assign stall      = (ev_want || flush_want) && pend_valid_r && !emit_ok;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_kind  = out_r.kind;
  assign out_ch.event_major = out_r.major_id;
  assign out_ch.event_minor = out_r.minor_id;
  assign out_ch.last_event  = out_last_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:   if (!q_stat.empty) state_nxt = BK_READ;
      BK_READ:   state_nxt = scan_done ? BK_INSERT : BK_EVAL;
      BK_EVAL:   if (!stall) state_nxt = BK_READ;
      BK_INSERT: if (!stall) state_nxt = BK_FLUSH;
      BK_FLUSH:  if (!stall) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_nxt        = job_r;
    rd_i_nxt       = rd_i_r;
    wr_w_nxt       = wr_w_r;
    count_nxt      = count_r;
    found_nxt      = found_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;
    mem_re         = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = wr_w_r[IDX_W-1:0];
    mem_wd         = '0;
    new_ev         = '0;

    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_head;
          rd_i_nxt  = '0;
          wr_w_nxt  = '0;
          found_nxt = 1'b0;
        end
      end
      BK_READ: begin
        mem_re = !scan_done;
      end
      BK_EVAL: begin
        new_ev.kind     = KIND_LEFT;
        new_ev.major_id = rd_data_r.major_id;
        new_ev.minor_id = rd_data_r.minor_id;
        if (expired) begin
          if (!stall) begin
            rd_i_nxt = rd_i_r + 1'b1;
          end
        end else begin
          // Survivors slide down to the write position; a matching one takes the new time.
          mem_we           = 1'b1;
          mem_wd.major_id  = rd_data_r.major_id;
          mem_wd.minor_id  = rd_data_r.minor_id;
          mem_wd.last_seen = hit ? job_r.now_seconds : rd_data_r.last_seen;
          wr_w_nxt         = wr_w_r + 1'b1;
          rd_i_nxt         = rd_i_r + 1'b1;
          found_nxt        = found_r || hit;
        end
      end
      BK_INSERT: begin
        new_ev.kind     = room ? KIND_ENTERED : KIND_DROPPED;
        new_ev.major_id = job_r.major_id;
        new_ev.minor_id = job_r.minor_id;
        if (!stall) begin
          count_nxt = wr_w_r;
          if (job_r.accept && !found_r && room) begin
            mem_we           = 1'b1;
            mem_wd.major_id  = job_r.major_id;
            mem_wd.minor_id  = job_r.minor_id;
            mem_wd.last_seen = job_r.now_seconds;
            count_nxt        = wr_w_r + 1'b1;
          end
        end
      end
      BK_FLUSH: begin
        if (pend_valid_r && !stall) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = pend_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    if (ev_want && !stall) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
        out_last_nxt  = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_nxt       = new_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    rd_i_r     <= rd_i_nxt;
    wr_w_r     <= wr_w_nxt;
    found_r    <= found_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= entry_mem[rd_i_r[IDX_W-1:0]];
    end
  end

endmodule

[rtl/core/beacon_presence_table.sv]
// Top level of the beacon presence table.
//
// Reports arrive on in_ch; every accepted transfer is one decoded beacon
// report. Each report first ages the table: entries older than the timeout
// are removed in place and produce a "left" event each. A report with the
// organisation UUID and enough signal then refreshes its entry or is
// inserted with an "entered" event, or flagged as dropped if the table is
// full. Events leave on out_ch; last_event marks the final one of a report.
// Registers are written over cfg_ch, which is always ready.
// A pass reads and evaluates each table entry in turn, then inserts the
// report and flushes the parked event. A two-deep queue lets reports
// arrive while a pass runs.
// When out_ch stalls, one event waits in the output register and one more
// is parked; the pass halts at the event after that until a transfer frees room.
// Reset empties the table and loads the default UUID, threshold and timeout.
module beacon_presence_table (
  input  logic      clk,
  input  logic      rst_n,
  bpt_in_if.sink    in_ch,
  bpt_out_if.source out_ch,
  bpt_cfg_if.sink   cfg_ch
);
  import bpt_pkg::*;

  logic        q_push;
  logic        q_pop;
  bpt_job_t    q_job;
  bpt_job_t    q_head;
  bpt_qstat_t  q_stat;
  logic [15:0] timeout;

  bpt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg_ch  (cfg_ch),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_job   (q_job),
    .timeout (timeout)
  );

  bpt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head_job (q_head),
    .stat     (q_stat)
  );

  bpt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_head  (q_head),
    .q_stat  (q_stat),
    .q_pop   (q_pop),
    .timeout (timeout),
    .out_ch  (out_ch)
  );

endmodule
